// ===== design/bcru_pkg.sv =====
// Package: types and codes shared across the branch/call/return unit.
`timescale 1ns / 1ps

package bcru_pkg;

   localparam logic [3:0] MODE_JP_REG  = 4'd0;
   localparam logic [3:0] MODE_JP_NN   = 4'd1;
   localparam logic [3:0] MODE_JR      = 4'd2;
   localparam logic [3:0] MODE_JR_CC   = 4'd3;
   localparam logic [3:0] MODE_JP_CC   = 4'd4;
   localparam logic [3:0] MODE_CALL    = 4'd5;
   localparam logic [3:0] MODE_CALL_CC = 4'd6;
   localparam logic [3:0] MODE_RET     = 4'd7;
   localparam logic [3:0] MODE_RET_CC  = 4'd8;
   localparam logic [3:0] MODE_RETI    = 4'd9;

   localparam logic [2:0] CYC_1 = 3'd1;
   localparam logic [2:0] CYC_2 = 3'd2;
   localparam logic [2:0] CYC_3 = 3'd3;
   localparam logic [2:0] CYC_4 = 3'd4;
   localparam logic [2:0] CYC_5 = 3'd5;
   localparam logic [2:0] CYC_6 = 3'd6;

   typedef struct packed {
      logic [3:0]  mode;
      logic [15:0] pc_now;
      logic [7:0]  imm_low;
      logic [7:0]  imm_high;
      logic [15:0] reg_value;
      logic [3:0]  flags;
      logic [1:0]  flag_select;
      logic        flag_want;
      logic [15:0] popped_word;
   } req_type;

   typedef struct packed {
      logic [15:0] next_pc;
      logic        taken;
      logic        push_valid;
      logic [15:0] push_word;
      logic        pop_used;
      logic        enable_interrupts;
      logic [2:0]  cycles;
   } rsp_type;

endpackage

// ===== design/bcru_chan_if.sv =====
// Interface: valid/ready channel carrying one word.
`timescale 1ns / 1ps

interface bcru_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/bcru_stage.sv =====
// Module: one valid/ready pipeline register stage.
`timescale 1ns / 1ps

module bcru_stage #(
   parameter type data_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     up_valid,
   output logic     up_ready,
   input  data_type up_word,
   output logic     dn_valid,
   input  logic     dn_ready,
   output data_type dn_word
);

   logic     valid_ff;
   logic     valid_in;
   data_type word_ff;
   data_type word_in;

   assign up_ready = !valid_ff || dn_ready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (up_ready) begin
         valid_in = up_valid;
         word_in  = up_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign dn_valid = valid_ff;
   assign dn_word  = word_ff;

endmodule

// ===== design/bcru_exec.sv =====
// Module: next-PC, stack and cycle-count logic for one control-flow word.
`timescale 1ns / 1ps

module bcru_exec (
   input  bcru_pkg::req_type req,
   output bcru_pkg::rsp_type rsp
);

   logic        cond;
   logic [15:0] pc1;
   logic [15:0] pc2;
   logic [15:0] target;
   logic [15:0] rel;

   assign cond   = (req.flags[req.flag_select] == req.flag_want);
   assign pc1    = req.pc_now + 16'd1;
   assign pc2    = req.pc_now + 16'd2;
   assign target = {req.imm_high, req.imm_low};
   // offset byte is two's complement
   assign rel    = pc1 + {{8{req.imm_low[7]}}, req.imm_low};

   always_comb begin
      rsp.next_pc           = req.pc_now;
      rsp.taken             = 1'b0;
      rsp.push_valid        = 1'b0;
      rsp.push_word         = 16'd0;
      rsp.pop_used          = 1'b0;
      rsp.enable_interrupts = 1'b0;
      rsp.cycles            = bcru_pkg::CYC_1;
      case (req.mode)
         bcru_pkg::MODE_JP_REG: begin
            rsp.next_pc = req.reg_value;
            rsp.taken   = 1'b1;
         end
         bcru_pkg::MODE_JP_NN: begin
            rsp.next_pc = target;
            rsp.taken   = 1'b1;
            rsp.cycles  = bcru_pkg::CYC_4;
         end
         bcru_pkg::MODE_JR: begin
            rsp.next_pc = rel;
            rsp.taken   = 1'b1;
            rsp.cycles  = bcru_pkg::CYC_3;
         end
         bcru_pkg::MODE_JR_CC: begin
            rsp.next_pc = cond ? rel : pc1;
            rsp.taken   = cond;
            rsp.cycles  = cond ? bcru_pkg::CYC_3 : bcru_pkg::CYC_2;
         end
         bcru_pkg::MODE_JP_CC: begin
            rsp.next_pc = cond ? target : pc2;
            rsp.taken   = cond;
            rsp.cycles  = cond ? bcru_pkg::CYC_4 : bcru_pkg::CYC_3;
         end
         bcru_pkg::MODE_CALL: begin
            rsp.next_pc    = target;
            rsp.taken      = 1'b1;
            rsp.push_valid = 1'b1;
            rsp.push_word  = pc2;
            rsp.cycles     = bcru_pkg::CYC_6;
         end
         bcru_pkg::MODE_CALL_CC: begin
            rsp.next_pc    = cond ? target : pc2;
            rsp.taken      = cond;
            rsp.push_valid = cond;
            rsp.push_word  = cond ? pc2 : 16'd0;
            rsp.cycles     = cond ? bcru_pkg::CYC_6 : bcru_pkg::CYC_3;
         end
         bcru_pkg::MODE_RET: begin
            rsp.next_pc  = req.popped_word;
            rsp.taken    = 1'b1;
            rsp.pop_used = 1'b1;
            rsp.cycles   = bcru_pkg::CYC_4;
         end
         bcru_pkg::MODE_RET_CC: begin
            rsp.next_pc  = cond ? req.popped_word : req.pc_now;
            rsp.taken    = cond;
            rsp.pop_used = cond;
            rsp.cycles   = cond ? bcru_pkg::CYC_5 : bcru_pkg::CYC_2;
         end
         bcru_pkg::MODE_RETI: begin
            rsp.next_pc           = req.popped_word;
            rsp.taken             = 1'b1;
            rsp.pop_used          = 1'b1;
            rsp.enable_interrupts = 1'b1;
            rsp.cycles            = bcru_pkg::CYC_4;
         end
         default: begin
            // unused modes: no-op, defaults above
            rsp.cycles = bcru_pkg::CYC_1;
         end
      endcase
   end

endmodule

// ===== design/branch_call_return_unit.sv =====
// Top level: control-flow execute stage, input register, logic, result register.
//
//   channel   dir  payload                 handshake
//   req_chan  in   bcru_pkg::req_type      valid/ready, taken when both high
//   rsp_chan  out  bcru_pkg::rsp_type      valid/ready, taken when both high
//
// A word accepted on req is captured in the input register, passes the logic and is
// captured in the result register, where it shows valid on rsp; one word per cycle
// sustained while rsp is not stalled, with a single register stage on each side of the logic.
// Synchronous active-high reset clears both stage valid bits.
// A stalled rsp holds its word; ready propagates back through both stages,
// so req keeps flowing while any stage has room.
`timescale 1ns / 1ps

module branch_call_return_unit (
   input logic    clock,
   input logic    reset,
   bcru_chan_if.sink   req_chan,
   bcru_chan_if.source rsp_chan
);

   logic              exec_valid;
   logic              exec_ready;
   bcru_pkg::req_type exec_req;
   bcru_pkg::rsp_type exec_rsp;

   bcru_stage #(.data_type(bcru_pkg::req_type)) u_req_stage (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_chan.valid),
      .up_ready (req_chan.ready),
      .up_word  (req_chan.payload),
      .dn_valid (exec_valid),
      .dn_ready (exec_ready),
      .dn_word  (exec_req)
   );

   bcru_exec u_exec (
      .req (exec_req),
      .rsp (exec_rsp)
   );

   bcru_stage #(.data_type(bcru_pkg::rsp_type)) u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .up_valid (exec_valid),
      .up_ready (exec_ready),
      .up_word  (exec_rsp),
      .dn_valid (rsp_chan.valid),
      .dn_ready (rsp_chan.ready),
      .dn_word  (rsp_chan.payload)
   );

endmodule

// ===== dv/bcru_checker.sv =====
// Checker: predicts each result word of the branch/call/return unit and compares it.
`timescale 1ns / 1ps

module bcru_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  bcru_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  bcru_pkg::rsp_type rsp_payload,
   output int unsigned       error_count,
   output int unsigned       pending_words
);

   bcru_pkg::rsp_type predicted_results[$];

   function automatic bcru_pkg::rsp_type predict_branch(bcru_pkg::req_type w);
      bcru_pkg::rsp_type r;
      logic              hit;
      logic [15:0]       pc1;
      logic [15:0]       pc2;
      logic [15:0]       target;
      logic [15:0]       rel;
      hit    = (w.flags[w.flag_select] == w.flag_want);
      pc1    = w.pc_now + 16'd1;
      pc2    = w.pc_now + 16'd2;
      target = {w.imm_high, w.imm_low};
      rel    = pc1 + {{8{w.imm_low[7]}}, w.imm_low};
      r         = '0;
      r.next_pc = w.pc_now;
      r.cycles  = bcru_pkg::CYC_1;
      case (w.mode)
         bcru_pkg::MODE_JP_REG: begin
            r.next_pc = w.reg_value;
            r.taken   = 1'b1;
            r.cycles  = bcru_pkg::CYC_1;
         end
         bcru_pkg::MODE_JP_NN: begin
            r.next_pc = target;
            r.taken   = 1'b1;
            r.cycles  = bcru_pkg::CYC_4;
         end
         bcru_pkg::MODE_JR: begin
            r.next_pc = rel;
            r.taken   = 1'b1;
            r.cycles  = bcru_pkg::CYC_3;
         end
         bcru_pkg::MODE_JR_CC: begin
            r.next_pc = hit ? rel : pc1;
            r.taken   = hit;
            r.cycles  = hit ? bcru_pkg::CYC_3 : bcru_pkg::CYC_2;
         end
         bcru_pkg::MODE_JP_CC: begin
            r.next_pc = hit ? target : pc2;
            r.taken   = hit;
            r.cycles  = hit ? bcru_pkg::CYC_4 : bcru_pkg::CYC_3;
         end
         bcru_pkg::MODE_CALL: begin
            r.next_pc    = target;
            r.taken      = 1'b1;
            r.push_valid = 1'b1;
            r.push_word  = pc2;
            r.cycles     = bcru_pkg::CYC_6;
         end
         bcru_pkg::MODE_CALL_CC: begin
            r.next_pc    = hit ? target : pc2;
            r.taken      = hit;
            r.push_valid = hit;
            r.push_word  = hit ? pc2 : 16'h0000;
            r.cycles     = hit ? bcru_pkg::CYC_6 : bcru_pkg::CYC_3;
         end
         bcru_pkg::MODE_RET: begin
            r.next_pc  = w.popped_word;
            r.taken    = 1'b1;
            r.pop_used = 1'b1;
            r.cycles   = bcru_pkg::CYC_4;
         end
         bcru_pkg::MODE_RET_CC: begin
            r.next_pc  = hit ? w.popped_word : w.pc_now;
            r.taken    = hit;
            r.pop_used = hit;
            r.cycles   = hit ? bcru_pkg::CYC_5 : bcru_pkg::CYC_2;
         end
         bcru_pkg::MODE_RETI: begin
            r.next_pc           = w.popped_word;
            r.taken             = 1'b1;
            r.pop_used          = 1'b1;
            r.enable_interrupts = 1'b1;
            r.cycles            = bcru_pkg::CYC_4;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      bcru_pkg::rsp_type want;
      if (reset) begin
         predicted_results.delete();
      end else begin
         if (req_valid && req_ready) begin
            predicted_results.push_back(predict_branch(req_payload));
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_results.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("unexpected word: pc=%h tk=%b push=%b/%h pop=%b ei=%b cyc=%0d",
                           rsp_payload.next_pc, rsp_payload.taken, rsp_payload.push_valid,
                           rsp_payload.push_word, rsp_payload.pop_used,
                           rsp_payload.enable_interrupts, rsp_payload.cycles);
               end
            end else begin
               want = predicted_results.pop_front();
               if (rsp_payload.next_pc !== want.next_pc ||
                   rsp_payload.taken !== want.taken ||
                   rsp_payload.push_valid !== want.push_valid ||
                   rsp_payload.push_word !== want.push_word ||
                   rsp_payload.pop_used !== want.pop_used ||
                   rsp_payload.enable_interrupts !== want.enable_interrupts ||
                   rsp_payload.cycles !== want.cycles) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("mismatch exp: pc=%h tk=%b push=%b/%h pop=%b ei=%b cyc=%0d",
                              want.next_pc, want.taken, want.push_valid, want.push_word,
                              want.pop_used, want.enable_interrupts, want.cycles);
                     $display("         act: pc=%h tk=%b push=%b/%h pop=%b ei=%b cyc=%0d",
                              rsp_payload.next_pc, rsp_payload.taken, rsp_payload.push_valid,
                              rsp_payload.push_word, rsp_payload.pop_used,
                              rsp_payload.enable_interrupts, rsp_payload.cycles);
                  end
               end
            end
         end
      end
      pending_words = predicted_results.size();
   end

endmodule

// ===== dv/tb.sv =====
// Testbench top: clock, reset, stimulus and verdict for the branch/call/return unit.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned QUIET_LIMIT = 3000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned PHASE_WORDS = 212;

   logic        clock;
   logic        reset;
   int unsigned idle_pct;
   int unsigned stall_pct;
   int unsigned hold_requests;
   int unsigned quiet_cycles;
   int unsigned error_count;
   int unsigned pending_words;

   bcru_chan_if #(.payload_type(bcru_pkg::req_type)) req_chan ();
   bcru_chan_if #(.payload_type(bcru_pkg::rsp_type)) rsp_chan ();

   branch_call_return_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bcru_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_payload   (req_chan.payload),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_payload   (rsp_chan.payload),
      .error_count   (error_count),
      .pending_words (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bcru_pkg::req_type random_word();
      bcru_pkg::req_type w;
      if ($urandom_range(99) < 8) begin
         w.mode = 4'($urandom_range(15, 10));
      end else begin
         w.mode = 4'($urandom_range(9, 0));
      end
      w.pc_now      = 16'($urandom);
      w.imm_low     = 8'($urandom);
      w.imm_high    = 8'($urandom);
      w.reg_value   = 16'($urandom);
      w.flags       = 4'($urandom);
      w.flag_select = 2'($urandom);
      w.flag_want   = 1'($urandom);
      w.popped_word = 16'($urandom);
      return w;
   endfunction

   // random word of the given mode with the condition forced to hit or miss
   function automatic bcru_pkg::req_type cond_word(logic [3:0] mode, logic hit);
      bcru_pkg::req_type w;
      w           = random_word();
      w.mode      = mode;
      w.flag_want = hit ? w.flags[w.flag_select] : ~w.flags[w.flag_select];
      return w;
   endfunction

   // entered and left at a falling edge; valid stays high on return
   task automatic send_word(bcru_pkg::req_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= w;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_words != 0) @(negedge clock);
   endtask

   initial begin
      int unsigned hold_left;
      int unsigned hold_seen;
      hold_left      = 0;
      hold_seen      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("[branch_call_return_unit] ERROR");
            $finish;
         end
      end
   end

   initial begin
      bcru_pkg::req_type w;
      int unsigned       phase;
      int unsigned       n;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      idle_pct         = 0;
      stall_pct        = 0;
      hold_requests    = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: every mode, both condition outcomes, offset and PC wrap edges
      w = random_word(); w.mode = bcru_pkg::MODE_JP_REG; w.reg_value = 16'hFFFF;
      send_word(w);
      w = random_word(); w.mode = bcru_pkg::MODE_JP_REG; w.reg_value = 16'h0000;
      send_word(w);
      w = random_word(); w.mode = bcru_pkg::MODE_JP_NN; w.imm_low = 8'hFF; w.imm_high = 8'hFF;
      send_word(w);
      w = random_word(); w.mode = bcru_pkg::MODE_JR; w.imm_low = 8'h7F; w.pc_now = 16'hFF80;
      send_word(w);
      w = random_word(); w.mode = bcru_pkg::MODE_JR; w.imm_low = 8'h80; w.pc_now = 16'h0000;
      send_word(w);
      w = random_word(); w.mode = bcru_pkg::MODE_JR; w.imm_low = 8'hFF; w.pc_now = 16'hFFFF;
      send_word(w);
      w = random_word(); w.mode = bcru_pkg::MODE_JR; w.imm_low = 8'h00; send_word(w);
      w = cond_word(bcru_pkg::MODE_JR_CC, 1'b1); w.imm_low = 8'hFE; send_word(w);
      w = cond_word(bcru_pkg::MODE_JR_CC, 1'b0); w.pc_now = 16'hFFFF; send_word(w);
      w = cond_word(bcru_pkg::MODE_JP_CC, 1'b1); send_word(w);
      w = cond_word(bcru_pkg::MODE_JP_CC, 1'b0); w.pc_now = 16'hFFFE; send_word(w);
      w = random_word(); w.mode = bcru_pkg::MODE_CALL; w.pc_now = 16'hFFFE; send_word(w);
      w = random_word(); w.mode = bcru_pkg::MODE_CALL; w.pc_now = 16'hFFFF; send_word(w);
      w = cond_word(bcru_pkg::MODE_CALL_CC, 1'b1); send_word(w);
      w = cond_word(bcru_pkg::MODE_CALL_CC, 1'b0); w.pc_now = 16'hFFFF; send_word(w);
      w = random_word(); w.mode = bcru_pkg::MODE_RET; w.popped_word = 16'hFFFF; send_word(w);
      w = cond_word(bcru_pkg::MODE_RET_CC, 1'b1); send_word(w);
      w = cond_word(bcru_pkg::MODE_RET_CC, 1'b0); send_word(w);
      w = random_word(); w.mode = bcru_pkg::MODE_RETI; w.popped_word = 16'h0000;
      send_word(w);
      w = random_word(); w.mode = 4'd10; send_word(w);
      w = random_word(); w.mode = 4'd15; send_word(w);
      drain();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 55; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 55; end
            default: begin idle_pct = 8; stall_pct = 8; end
         endcase
         for (n = 0; n < PHASE_WORDS; n++) begin
            if (phase == 0 && n == 40) hold_requests++;
            if (phase == 3 && n == 100) drain();
            send_word(random_word());
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("[branch_call_return_unit] OK");
      end else begin
         $display("[branch_call_return_unit] ERROR");
      end
      $finish;
   end

endmodule

// ===== branch_call_return_unit.f =====
design/bcru_pkg.sv
design/bcru_chan_if.sv
design/bcru_stage.sv
design/bcru_exec.sv
design/branch_call_return_unit.sv
dv/bcru_checker.sv
dv/tb.sv
